// File: sv/mhic_pkg.sv
`timescale 1ns / 1ps

package mhic_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CNT_W            = 16;
    localparam int OP_W             = 3;
    localparam int MODE_W           = 2;
    localparam int NUM_AXES         = 3;

    localparam logic [CNT_W-1:0] MIN_SAMPLES_RST = CNT_W'(200);

    localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_SAVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
    localparam logic [OP_W-1:0] OP_APPLY  = 3'd5;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAVED    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 2'd3;

endpackage

// File: sv/mag_hard_iron_calibrator_core.sv
`timescale 1ns / 1ps

// Hard-iron magnetometer calibrator, min/max method.
// Input channel (i_valid / o_ready) carries one operation per transfer: a raw
// sample, start, save, cancel, clear, or apply of given offsets. Output
// channel (o_valid / i_ready) returns exactly one status result per operation,
// in order: mode, sample count, the three reported offsets (max plus min, in
// half-LSB units), the applied flag, save success and a fusion-reset request.
// The item is captured in an input register; when it advances, the state is
// updated and the result goes to the output register behind o_valid. Throughput
// is one item per cycle unless the receiver stalls: all per-item work is two
// compares and one add per axis between the two registers. When the receiver
// stalls, the result holds in the output register and the input register still
// takes one more item; o_ready drops only once both are full. Synchronous
// active-low reset empties both registers, sets the mode to idle, clears the
// counter, offsets and flags, and loads min_samples with 200. The user writes
// min_samples via i_cfg_we / i_cfg_wdata only while idle; not enforced.
module mag_hard_iron_calibrator_core
    import mhic_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CNT_W-1:0]               i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [OP_W-1:0]                i_op,
    input  logic signed [SAMPLE_WIDTH-1:0] i_mag_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_mag_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_mag_z,
    input  logic signed [SAMPLE_WIDTH+1:0] i_set_off_x,
    input  logic signed [SAMPLE_WIDTH+1:0] i_set_off_y,
    input  logic signed [SAMPLE_WIDTH+1:0] i_set_off_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [MODE_W-1:0]              o_cal_state,
    output logic [CNT_W-1:0]               o_samples_taken,
    output logic signed [SAMPLE_WIDTH+1:0] o_offset_x,
    output logic signed [SAMPLE_WIDTH+1:0] o_offset_y,
    output logic signed [SAMPLE_WIDTH+1:0] o_offset_z,
    output logic                           o_cal_active,
    output logic                           o_save_ok,
    output logic                           o_fusion_reset
);

    localparam int OFF_W = SAMPLE_WIDTH + 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [OFF_W-1:0]        t_offset;

    // Configuration
    logic [CNT_W-1:0] r_min_samples;

    // Input register
    logic             r_in_valid;
    logic [OP_W-1:0]  r_in_op;
    t_sample          r_in_mag [NUM_AXES];
    t_offset          r_in_set [NUM_AXES];

    // Calibration state
    logic [MODE_W-1:0] r_mode,    n_mode;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    t_sample           r_min     [NUM_AXES];
    t_sample           n_min     [NUM_AXES];
    t_sample           r_max     [NUM_AXES];
    t_sample           n_max     [NUM_AXES];
    t_offset           r_off     [NUM_AXES];
    t_offset           n_off     [NUM_AXES];
    t_offset           r_boff    [NUM_AXES];
    t_offset           n_boff    [NUM_AXES];
    logic              r_bvalid,  n_bvalid;
    logic              r_applied, n_applied;
    logic              n_ok;
    logic              n_freset;

    // Output register
    logic              r_out_valid;
    logic [MODE_W-1:0] r_out_mode;
    logic [CNT_W-1:0]  r_out_cnt;
    t_offset           r_out_off [NUM_AXES];
    logic              r_out_applied;
    logic              r_out_ok;
    logic              r_out_freset;

    logic w_adv;
    logic w_in_take;

    assign w_adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_adv;
    assign w_in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_samples <= MIN_SAMPLES_RST;
        end else if (i_cfg_we) begin
            r_min_samples <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op     <= i_op;
            r_in_mag[0] <= i_mag_x;
            r_in_mag[1] <= i_mag_y;
            r_in_mag[2] <= i_mag_z;
            r_in_set[0] <= i_set_off_x;
            r_in_set[1] <= i_set_off_y;
            r_in_set[2] <= i_set_off_z;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_cnt     = r_cnt;
        n_bvalid  = r_bvalid;
        n_applied = r_applied;
        n_ok      = 1'b0;
        n_freset  = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            n_min[i]  = r_min[i];
            n_max[i]  = r_max[i];
            n_off[i]  = r_off[i];
            n_boff[i] = r_boff[i];
        end

        unique case (r_in_op)
            OP_SAMPLE: begin
                if (r_mode == MODE_SAMPLING) begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        // The first sample of a session seeds both extremes.
                        if (r_cnt == '0 || r_in_mag[i] < r_min[i]) begin
                            n_min[i] = r_in_mag[i];
                        end
                        if (r_cnt == '0 || r_in_mag[i] > r_max[i]) begin
                            n_max[i] = r_in_mag[i];
                        end
                        n_off[i] = {{2{n_max[i][SAMPLE_WIDTH-1]}}, n_max[i]}
                                 + {{2{n_min[i][SAMPLE_WIDTH-1]}}, n_min[i]};
                    end
                    if (r_cnt != {CNT_W{1'b1}}) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            OP_START: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    n_boff[i] = r_applied ? r_off[i] : '0;
                    n_min[i]  = '0;
                    n_max[i]  = '0;
                    n_off[i]  = '0;
                end
                n_bvalid  = r_applied;
                n_applied = 1'b0;
                n_mode    = MODE_SAMPLING;
                n_cnt     = '0;
                n_freset  = 1'b1;
            end
            OP_SAVE: begin
                if (r_cnt < r_min_samples) begin
                    n_mode = MODE_ERROR;
                end else begin
                    n_mode    = MODE_SAVED;
                    n_applied = 1'b1;
                    n_bvalid  = 1'b0;
                    n_ok      = 1'b1;
                    n_freset  = 1'b1;
                end
            end
            OP_CANCEL: begin
                n_cnt = '0;
                for (int i = 0; i < NUM_AXES; i++) begin
                    n_off[i] = r_bvalid ? r_boff[i] : '0;
                end
                n_mode    = r_bvalid ? MODE_SAVED : MODE_IDLE;
                n_applied = r_bvalid;
                n_bvalid  = 1'b0;
                n_freset  = 1'b1;
            end
            OP_CLEAR: begin
                // The reported offsets are deliberately left as they are.
                n_applied = 1'b0;
                n_mode    = MODE_IDLE;
                n_cnt     = '0;
                n_bvalid  = 1'b0;
                n_freset  = 1'b1;
            end
            OP_APPLY: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    n_off[i] = r_in_set[i];
                end
                n_mode    = MODE_SAVED;
                n_applied = 1'b1;
                n_bvalid  = 1'b0;
                n_ok      = 1'b1;
                n_freset  = 1'b1;
            end
            default: begin
                // Unused operation codes leave the state alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_cnt     <= '0;
            r_bvalid  <= 1'b0;
            r_applied <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_off[i] <= '0;
            end
        end else if (w_adv) begin
            r_mode    <= n_mode;
            r_cnt     <= n_cnt;
            r_bvalid  <= n_bvalid;
            r_applied <= n_applied;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_off[i] <= n_off[i];
            end
        end
    end

    // Extremes are seeded by the first sample and the backup is read only when
    // valid, so neither needs a reset.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_min[i]  <= n_min[i];
                r_max[i]  <= n_max[i];
                r_boff[i] <= n_boff[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_mode    <= n_mode;
            r_out_cnt     <= n_cnt;
            r_out_applied <= n_applied;
            r_out_ok      <= n_ok;
            r_out_freset  <= n_freset;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_out_off[i] <= n_off[i];
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cal_state     = r_out_mode;
    assign o_samples_taken = r_out_cnt;
    assign o_offset_x      = r_out_off[0];
    assign o_offset_y      = r_out_off[1];
    assign o_offset_z      = r_out_off[2];
    assign o_cal_active    = r_out_applied;
    assign o_save_ok       = r_out_ok;
    assign o_fusion_reset  = r_out_freset;

    // A successful save or apply always asks for a filter reset and leaves
    // the offsets applied in the saved mode.
    a_ok_implies_saved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok) |->
            (r_out_freset && r_out_applied && r_out_mode == MODE_SAVED))
        else $error("save_ok without saved, applied state");

    // A pending backup exists only during or just after a failed session.
    a_backup_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bvalid |-> (r_mode == MODE_SAMPLING || r_mode == MODE_ERROR))
        else $error("backup valid outside a calibration session");

    a_backup_not_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bvalid |-> !r_applied)
        else $error("backup valid while offsets applied");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_op == OP_START) |=>
            (r_cnt == '0 && r_mode == MODE_SAMPLING && !r_applied))
        else $error("start did not open a clean session");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid && $stable(r_in_op))
        else $error("input register lost an item under back-pressure");

endmodule
